// ----- rtl/ast_pkg.sv -----
// Shared constants, register indexes and control types for the stutter looper.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none
package ast_pkg;

    localparam int BUFFER_DEPTH_DEF = 65536;
    localparam int FADE_MAX_DEF     = 64;

    localparam int SAMPLE_W  = 16;
    localparam int FRAC_BITS = 12;
    localparam int OFS_W     = 28;
    localparam int LEN_W     = 16;
    localparam int STEP_W    = 15;

    localparam int LEN_MIN  = 32;
    localparam int STEP_MIN = 205;
    localparam int STEP_MAX = 16384;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SLICE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_PLAY = 2'd2;

    localparam logic [LEN_W-1:0]  LEN_RESET  = 16'd4410;
    localparam logic [STEP_W-1:0] STEP_RESET = 15'd4096;

    typedef struct packed {
        logic wr;
        logic rd;
    } mem_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/ast_if.sv -----
// Stream interfaces for the sample input and output channels.
// Depends on ast_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ast_in_if
    import ast_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic                       slice_gate;
    logic                       take_slice;

    modport source (output valid, in_sample, slice_gate, take_slice, input ready);
    modport sink   (input valid, in_sample, slice_gate, take_slice, output ready);
endinterface

interface ast_out_if
    import ast_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_sample;

    modport source (output valid, out_sample, input ready);
    modport sink   (input valid, out_sample, output ready);
endinterface
`default_nettype wire

// ----- rtl/ast_mem.sv -----
// Single-port circular sample buffer with a zero sweep after reset.
// Depends on ast_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ast_mem
    import ast_pkg::*;
#(
    parameter int DEPTH = BUFFER_DEPTH_DEF,
    parameter int AW    = $clog2(BUFFER_DEPTH_DEF)
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mem_ctl_t            ctl,
    input  wire logic [AW-1:0]       addr,
    input  wire logic [SAMPLE_W-1:0] wdata,
    output logic      [SAMPLE_W-1:0] rdata,
    output logic                     ready
);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [AW-1:0]       clr_cnt_reg;
    logic                clr_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (ctl.wr)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd)
        begin
            rdata <= mem[addr];
        end
    end

    assign ready = !clr_busy_reg;

endmodule
`default_nettype wire

// ----- rtl/ast_mul.sv -----
// Bit-serial signed-by-unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on ast_pkg only for the shared import style.
`timescale 1ns / 1ps
`default_nettype none
module ast_mul
    import ast_pkg::*;
#(
    parameter int MA = 30,
    parameter int MB = 19
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [MA-1:0] a,
    input  wire logic        [MB-1:0] b,
    output logic                      busy,
    output logic signed [MA+MB-1:0]   p
);

    localparam int CW = $clog2(MB + 1);

    logic [CW-1:0]          cnt_reg;
    logic                   busy_reg;
    logic signed [MA-1:0]   a_reg;
    logic [MA+MB:0]         prod_reg;
    logic signed [MA:0]     hi;
    logic signed [MA:0]     sum;

    always_comb
    begin
        hi  = $signed(prod_reg[MA+MB:MB]);
        sum = hi + (prod_reg[0] ? {a_reg[MA-1], a_reg} : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(MB);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= a;
            prod_reg <= {{(MA+1){1'b0}}, b};
        end
        else if (busy_reg)
        begin
            prod_reg <= {sum[MA], sum, prod_reg[MB-1:1]};
        end
    end

    assign busy = busy_reg;
    assign p    = $signed(prod_reg[MA+MB-1:0]);

endmodule
`default_nettype wire

// ----- rtl/ast_div.sv -----
// Restoring divider, one quotient bit per cycle, divisor shifted right each step.
// Depends on ast_pkg only for the shared import style.
`timescale 1ns / 1ps
`default_nettype none
module ast_div
    import ast_pkg::*;
#(
    parameter int DV_W = 38,
    parameter int DS_W = 19,
    parameter int Q_W  = 17
)(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [DV_W-1:0] dividend,
    input  wire logic [DS_W-1:0] divisor,
    output logic                 busy,
    output logic [Q_W-1:0]       quot
);

    localparam int CW = $clog2(Q_W + 1);

    logic [CW-1:0]   cnt_reg;
    logic            busy_reg;
    logic [DV_W-1:0] rem_reg;
    logic [DV_W-1:0] dsr_reg;
    logic [Q_W-1:0]  q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(Q_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dsr_reg <= DV_W'(divisor) << (Q_W - 1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsr_reg)
            begin
                rem_reg <= rem_reg - dsr_reg;
                q_reg   <= {q_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[Q_W-2:0], 1'b0};
            end
            dsr_reg <= dsr_reg >> 1;
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule
`default_nettype wire

// ----- rtl/audio_stutter_looper.sv -----
// Top level of the beat-repeat stutter looper: sequencer, slice state, offset wrap.
// Depends on ast_pkg, ast_if, ast_mem, ast_mul, ast_div.
//
//  channel  | dir | transfer when      | payload
//  ---------+-----+--------------------+--------------------------------------
//  in_ch    | in  | valid && ready     | in_sample, slice_gate, take_slice
//  out_ch   | out | valid && ready     | out_sample
//  cfg      | in  | cfg_we             | cfg_index, cfg_data (write only)
//
// A disarmed sample goes from S_IDLE through S_OUT into the output register.
// An armed sample makes two buffer reads on the single memory port, then runs
// the bit-serial multiplier twice (interpolation, fade gain) and the serial
// divider. in_ch.ready returns once the sequencer is back in S_IDLE after the
// output load, so a new sample is taken only when the last one is through.
// After reset the buffer is swept to zero; in_ch.ready
// stays low until it is done. While the output register is still full, the
// sequencer waits in its final state with the next result held.
`timescale 1ns / 1ps
`default_nettype none
module audio_stutter_looper
    import ast_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    parameter int FADE_MAX     = FADE_MAX_DEF
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ast_in_if.sink                     in_ch,
    ast_out_if.source                  out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW      = $clog2(BUFFER_DEPTH);
    localparam int LEN_MAX = (BUFFER_DEPTH - 2 > 65534) ? 65534 : BUFFER_DEPTH - 2;
    localparam int EQ_MAX  = FADE_MAX * 4096;
    localparam int NUM_W   = $clog2(EQ_MAX + 1);
    localparam int V_W     = 30;
    localparam int P_W     = V_W + NUM_W;
    localparam int PS_W    = P_W - FRAC_BITS;
    localparam int DV_W    = PS_W + 1;
    localparam int Q_W     = 17;
    localparam int MOD_K   = 12;
    localparam int MR_W    = OFS_W + 1;
    localparam int MD_W    = OFS_W + MOD_K - 1;
    localparam int IX_W    = ((AW > LEN_W) ? AW : LEN_W) + 1;
    localparam int EXT_W   = V_W - SAMPLE_W - FRAC_BITS;

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD0  = 4'd1;
    localparam logic [3:0] S_RD1  = 4'd2;
    localparam logic [3:0] S_RD2  = 4'd3;
    localparam logic [3:0] S_MUL1 = 4'd4;
    localparam logic [3:0] S_ADJ  = 4'd5;
    localparam logic [3:0] S_NUM  = 4'd6;
    localparam logic [3:0] S_MUL2 = 4'd7;
    localparam logic [3:0] S_DIVP = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    // configuration
    logic [LEN_W-1:0]  len_reg;
    logic [STEP_W-1:0] step_reg;
    logic              rev_reg;

    // loop state
    logic [3:0]           state_reg;
    logic [AW-1:0]        wh_reg;
    logic [AW-1:0]        start_reg;
    logic [OFS_W-1:0]     off_reg;
    logic                 armed_reg;
    logic [SAMPLE_W-1:0]  s0_reg;
    logic signed [V_W-1:0] v_reg;
    logic [MR_W-1:0]      mrem_reg;
    logic [MD_W-1:0]      mdiv_reg;
    logic [3:0]           mcnt_reg;
    logic                 neg_reg;
    logic signed [SAMPLE_W-1:0] sat_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;
    logic                 out_vld_reg;

    // derived values
    logic [LEN_W-1:0]    eff_len;
    logic [STEP_W-1:0]   eff_step;
    logic [OFS_W-1:0]    lq;
    logic [LEN_W+9:0]    l1024;
    logic [NUM_W-1:0]    eq;
    logic [AW-1:0]       wh_inc;
    logic [IX_W-1:0]     cap_sum;
    logic [AW-1:0]       cap_start;
    logic [IX_W-1:0]     rd_sum;
    logic [AW-1:0]       i0;
    logic [AW-1:0]       i1;
    logic [NUM_W-1:0]    num;
    logic [OFS_W-1:0]    off_adj;
    logic                in_xfer;
    logic                armed_next;

    // memory and serial units
    mem_ctl_t             mem_ctl;
    logic [AW-1:0]        mem_addr;
    logic [SAMPLE_W-1:0]  mem_rdata;
    logic                 mem_ready;
    logic                 mul_start;
    logic signed [V_W-1:0] mul_a;
    logic [NUM_W-1:0]     mul_b;
    logic                 mul_busy;
    logic signed [P_W-1:0] mul_p;
    logic                 div_start;
    logic [DV_W-1:0]      div_dvd;
    logic                 div_busy;
    logic [Q_W-1:0]       div_q;
    logic [SAMPLE_W:0]    diff;
    logic signed [PS_W-1:0] p_sh;
    logic signed [Q_W:0]  res;

    // register writes; the host must write only while no sample is in flight (not enforced here)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= LEN_RESET;
            step_reg <= STEP_RESET;
            rev_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SLICE_LENGTH: len_reg  <= cfg_data[LEN_W-1:0];
                REG_PITCH_STEP:   step_reg <= cfg_data[STEP_W-1:0];
                REG_REVERSE_PLAY: rev_reg  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // registers are clamped at use
    always_comb
    begin
        priority if (len_reg < LEN_W'(LEN_MIN))
            eff_len = LEN_W'(LEN_MIN);
        else if (len_reg > LEN_W'(LEN_MAX))
            eff_len = LEN_W'(LEN_MAX);
        else
            eff_len = len_reg;

        priority if (step_reg < STEP_W'(STEP_MIN))
            eff_step = STEP_W'(STEP_MIN);
        else if (step_reg > STEP_W'(STEP_MAX))
            eff_step = STEP_W'(STEP_MAX);
        else
            eff_step = step_reg;

        lq    = {eff_len, {FRAC_BITS{1'b0}}};
        l1024 = {eff_len, 10'b0};
        // fade edge: min(L/4, FADE_MAX) samples in Q.12
        if (OFS_W'(l1024) > OFS_W'(EQ_MAX))
            eq = NUM_W'(EQ_MAX);
        else
            eq = l1024[NUM_W-1:0];
    end

    // head arithmetic: every sum stays below twice the depth
    always_comb
    begin
        wh_inc  = (wh_reg == AW'(BUFFER_DEPTH - 1)) ? '0 : wh_reg + 1'b1;
        cap_sum = IX_W'(wh_inc) + IX_W'(BUFFER_DEPTH) - IX_W'(eff_len);
        if (cap_sum >= IX_W'(BUFFER_DEPTH))
            cap_sum = cap_sum - IX_W'(BUFFER_DEPTH);
        cap_start = cap_sum[AW-1:0];

        rd_sum = IX_W'(start_reg) + IX_W'(off_reg[OFS_W-1:FRAC_BITS]);
        if (rd_sum >= IX_W'(BUFFER_DEPTH))
            rd_sum = rd_sum - IX_W'(BUFFER_DEPTH);
        i0 = rd_sum[AW-1:0];
        i1 = (i0 == AW'(BUFFER_DEPTH - 1)) ? '0 : i0 + 1'b1;
    end

    // reverse step after the wrap, then fade numerator from the stepped offset
    always_comb
    begin
        if (!rev_reg)
            off_adj = mrem_reg[OFS_W-1:0];
        else if (mrem_reg >= MR_W'(eff_step))
            off_adj = OFS_W'(mrem_reg - MR_W'(eff_step));
        else
            off_adj = OFS_W'(mrem_reg + MR_W'(lq) - MR_W'(eff_step));

        priority if (off_reg < OFS_W'(eq))
            num = off_reg[NUM_W-1:0];
        else if (off_reg > lq - OFS_W'(eq))
            num = NUM_W'(lq - off_reg);
        else
            num = eq;
    end

    assign in_xfer    = in_ch.valid && in_ch.ready;
    assign armed_next = in_ch.slice_gate ? in_ch.take_slice : armed_reg;
    assign diff       = {mem_rdata[SAMPLE_W-1], mem_rdata} - {s0_reg[SAMPLE_W-1], s0_reg};
    assign p_sh       = mul_p[P_W-1:FRAC_BITS];

    always_comb
    begin
        res = neg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    end

    // memory port and unit starts
    always_comb
    begin
        mem_ctl   = '0;
        mem_addr  = wh_reg;
        mul_start = 1'b0;
        mul_a     = v_reg;
        mul_b     = num;
        div_start = 1'b0;
        if (p_sh < 0)
            div_dvd = DV_W'(-$signed({p_sh[PS_W-1], p_sh})) + DV_W'(eq) - 1'b1;
        else
            div_dvd = DV_W'(p_sh);
        unique case (state_reg)
            S_IDLE:
            begin
                mem_ctl.wr = in_xfer;
            end
            S_RD0:
            begin
                mem_ctl.rd = 1'b1;
                mem_addr   = i0;
            end
            S_RD1:
            begin
                mem_ctl.rd = 1'b1;
                mem_addr   = i1;
            end
            S_RD2:
            begin
                mul_start = 1'b1;
                mul_a     = V_W'($signed(diff));
                mul_b     = NUM_W'(off_reg[FRAC_BITS-1:0]);
            end
            S_NUM:  mul_start = 1'b1;
            S_DIVP: div_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            wh_reg      <= '0;
            start_reg   <= '0;
            off_reg     <= '0;
            armed_reg   <= 1'b0;
            mcnt_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            // output register: a new load wins over the outgoing transfer
            if ((state_reg == S_OUT) && (!out_vld_reg || out_ch.ready))
                out_vld_reg <= 1'b1;
            else if (out_ch.valid && out_ch.ready)
                out_vld_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        wh_reg    <= wh_inc;
                        armed_reg <= armed_next;
                        if (in_ch.slice_gate && in_ch.take_slice)
                        begin
                            start_reg <= cap_start;
                            off_reg   <= rev_reg ? lq : '0;
                        end
                        sat_reg   <= in_ch.in_sample;
                        state_reg <= armed_next ? S_RD0 : S_OUT;
                    end
                end
                S_RD0: state_reg <= S_RD1;
                S_RD1:
                begin
                    s0_reg    <= mem_rdata;
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    // offset wrap runs beside the interpolation multiply
                    mrem_reg  <= MR_W'(off_reg) + (rev_reg ? '0 : MR_W'(eff_step));
                    mdiv_reg  <= MD_W'(lq) << (MOD_K - 1);
                    mcnt_reg  <= 4'(MOD_K);
                    state_reg <= S_MUL1;
                end
                S_MUL1:
                begin
                    if (mcnt_reg != '0)
                    begin
                        if (MD_W'(mrem_reg) >= mdiv_reg)
                            mrem_reg <= MR_W'(MD_W'(mrem_reg) - mdiv_reg);
                        mdiv_reg <= mdiv_reg >> 1;
                        mcnt_reg <= mcnt_reg - 1'b1;
                    end
                    else if (!mul_busy)
                    begin
                        v_reg <= $signed({{EXT_W{s0_reg[SAMPLE_W-1]}}, s0_reg,
                                          {FRAC_BITS{1'b0}}}) + mul_p[V_W-1:0];
                        state_reg <= S_ADJ;
                    end
                end
                S_ADJ:
                begin
                    off_reg   <= off_adj;
                    state_reg <= S_NUM;
                end
                S_NUM: state_reg <= S_MUL2;
                S_MUL2:
                begin
                    if (!mul_busy)
                        state_reg <= S_DIVP;
                end
                S_DIVP:
                begin
                    neg_reg   <= p_sh < 0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (!div_busy)
                    begin
                        priority if (res > (Q_W+1)'(32767))
                            sat_reg <= 16'sh7FFF;
                        else if (res < -$signed((Q_W+1)'(32768)))
                            sat_reg <= 16'sh8000;
                        else
                            sat_reg <= res[SAMPLE_W-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_vld_reg || out_ch.ready)
                    begin
                        out_data_reg <= sat_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ch.ready       = (state_reg == S_IDLE) && mem_ready;
    assign out_ch.valid      = out_vld_reg;
    assign out_ch.out_sample = out_data_reg;

    ast_mem #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (in_ch.in_sample),
        .rdata (mem_rdata),
        .ready (mem_ready)
    );

    ast_mul #(
        .MA (V_W),
        .MB (NUM_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .p     (mul_p)
    );

    ast_div #(
        .DV_W (DV_W),
        .DS_W (NUM_W),
        .Q_W  (Q_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (eq),
        .busy     (div_busy),
        .quot     (div_q)
    );

endmodule
`default_nettype wire

// ----- verif/audio_stutter_looper_tb.sv -----
// Self-checking testbench for audio_stutter_looper: directed table, then random phases.
// Depends on ast_pkg, ast_if (rtl) and the audio_stutter_looper top level.
`timescale 1ns / 1ps
`default_nettype none
module audio_stutter_looper_tb;
    import ast_pkg::*;

    localparam int                   DEPTH       = 65536;
    localparam int                   FADE_SAMPS  = 64;
    localparam int                   LEN_HI      = DEPTH - 2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;   // not a register, must be ignored
    localparam int                   DRAIN_WAIT  = 120;    // longer than the armed sample path
    localparam int                   IDLE_LIMIT  = 200000; // covers the buffer sweep after reset
    localparam int                   HOLD_CYCLES = 400;
    localparam int                   PHASE_ITEMS = 120;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ast_in_if  in_ch ();
    ast_out_if out_ch ();

    audio_stutter_looper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Looper model: its own copy of the sample store, heads and registers
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] loop_mem [DEPTH];
    int unsigned                wr_head;
    int unsigned                slc_start;
    longint unsigned            slc_ofs;   // Q.12 offset inside the slice
    bit                         slc_armed;
    logic [LEN_W-1:0]           len_reg;
    logic [STEP_W-1:0]          step_reg;
    bit                         rev_reg;

    logic signed [SAMPLE_W-1:0] pending_out [$];

    int  fail_count;
    bit  quiet;        // no idling on either side in the closing phase
    int  hold_asks;    // bumped by the sender to ask the receiver for a long stall

    function automatic longint floor_div(longint p, longint d);
        longint q;
        q = p / d;
        if ((p % d) != 0 && p < 0)
            q = q - 1;
        return q;
    endfunction

    // One sample through the looper: write, gate handling, then the read side.
    function automatic logic signed [SAMPLE_W-1:0] stutter_sample(
        logic signed [SAMPLE_W-1:0] smp, bit gate, bit take);
        longint unsigned lenq, lq, stp, o, eq, num, f;
        int unsigned     i0, i1;
        longint          v, res;
        lenq = len_reg;
        if (lenq < LEN_MIN) lenq = LEN_MIN;
        if (lenq > LEN_HI)  lenq = LEN_HI;
        lq = lenq << FRAC_BITS;

        loop_mem[wr_head] = smp;
        wr_head = (wr_head + 1) % DEPTH;

        if (gate)
        begin
            if (take)
            begin
                slc_start = (wr_head + DEPTH - lenq) % DEPTH;
                slc_ofs   = rev_reg ? lq : 0;
                slc_armed = 1'b1;
            end
            else
                slc_armed = 1'b0;
        end

        if (!slc_armed)
            res = loop_mem[(wr_head + DEPTH - 1) % DEPTH];
        else
        begin
            i0 = (slc_start + (slc_ofs >> FRAC_BITS)) % DEPTH;
            i1 = (i0 + 1) % DEPTH;
            f  = slc_ofs & 64'd4095;
            v  = longint'(loop_mem[i0]) * longint'(4096 - f) + longint'(loop_mem[i1]) * longint'(f);
            stp = step_reg;
            if (stp < STEP_MIN) stp = STEP_MIN;
            if (stp > STEP_MAX) stp = STEP_MAX;
            if (rev_reg)
            begin
                o = slc_ofs % lq;
                slc_ofs = (o >= stp) ? o - stp : o + lq - stp;
                slc_ofs = slc_ofs % lq;
            end
            else
                slc_ofs = (slc_ofs + stp) % lq;
            // fade edge: min(L/4, FADE_MAX) samples in Q.12
            eq = lenq * 1024;
            if (eq > FADE_SAMPS * 4096) eq = FADE_SAMPS * 4096;
            num = eq;
            if (slc_ofs < eq)           num = slc_ofs;
            else if (slc_ofs > lq - eq) num = lq - slc_ofs;
            res = floor_div(v * longint'(num), longint'(eq) * 4096);
        end
        if (res > 32767)  res = 32767;
        if (res < -32768) res = -32768;
        return res[SAMPLE_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_SLICE_LENGTH: len_reg  = val;
            REG_PITCH_STEP:   step_reg = val[STEP_W-1:0];
            REG_REVERSE_PLAY: rev_reg  = val[0];
            default: ;
        endcase
    endtask

    // Offer one sample; returns at the edge where the transfer happened.
    // typed_ok: use exp_val as the expectation instead of the model's value.
    task automatic send_sample(logic signed [SAMPLE_W-1:0] smp, bit gate, bit take,
                               bit typed_ok, logic signed [SAMPLE_W-1:0] exp_val);
        logic signed [SAMPLE_W-1:0] model_val;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.in_sample  <= smp;
        in_ch.slice_gate <= gate;
        in_ch.take_slice <= take;
        do
            @(posedge clk);
        while (!in_ch.ready);
        model_val = stutter_sample(smp, gate, take);
        pending_out.push_back(typed_ok ? exp_val : model_val);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Mostly plain samples with occasional gate edges, mostly captures.
    task automatic random_phase(int n);
        bit gate, take;
        for (int k = 0; k < n; k++)
        begin
            gate = ($urandom_range(0, 15) == 0);
            take = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
                send_sample($urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000, gate, take, 1'b0, '0);
            else
                send_sample(16'($urandom), gate, take, 1'b0, '0);
        end
    endtask

    typedef struct {
        logic signed [SAMPLE_W-1:0] smp;
        bit                         gate;
        bit                         take;
        bit                         typed_ok;
        logic signed [SAMPLE_W-1:0] exp_val;
    } stim_row_t;

    // Runs under the reset register values. Disarmed rows echo the written sample.
    stim_row_t directed_rows [16] = '{
        '{16'sh7FFF,  1'b0, 1'b0, 1'b1, 16'sh7FFF},
        '{-16'sh8000, 1'b0, 1'b0, 1'b1, -16'sh8000},
        '{16'sh0000,  1'b0, 1'b0, 1'b1, 16'sh0000},
        '{-16'sh0001, 1'b0, 1'b0, 1'b1, -16'sh0001},
        '{16'sh04D2,  1'b1, 1'b0, 1'b1, 16'sh04D2},  // disarm while already disarmed
        '{16'sh0007,  1'b0, 1'b1, 1'b1, 16'sh0007},  // take without gate is ignored
        '{16'sh5555,  1'b1, 1'b1, 1'b0, '0},         // capture and arm
        '{-16'sh5556, 1'b0, 1'b0, 1'b0, '0},
        '{16'sh7FFF,  1'b0, 1'b0, 1'b0, '0},
        '{-16'sh8000, 1'b0, 1'b1, 1'b0, '0},
        '{16'sh1234,  1'b1, 1'b1, 1'b0, '0},         // recapture while armed
        '{16'sh0001,  1'b0, 1'b0, 1'b0, '0},
        '{16'sh0005,  1'b1, 1'b0, 1'b1, 16'sh0005},  // disarm
        '{-16'sh0005, 1'b0, 1'b0, 1'b1, -16'sh0005},
        '{16'sh2AAA,  1'b1, 1'b1, 1'b0, '0},
        '{-16'sh2AAB, 1'b0, 1'b0, 1'b0, '0}
    };

    initial
    begin
        fail_count       = 0;
        quiet            = 1'b0;
        hold_asks        = 0;
        wr_head          = 0;
        slc_start        = 0;
        slc_ofs          = 0;
        slc_armed        = 1'b0;
        len_reg          = LEN_RESET;
        step_reg         = STEP_RESET;
        rev_reg          = 1'b0;
        foreach (loop_mem[i]) loop_mem[i] = '0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.in_sample  = '0;
        in_ch.slice_gate = 1'b0;
        in_ch.take_slice = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            send_sample(directed_rows[r].smp, directed_rows[r].gate, directed_rows[r].take,
                        directed_rows[r].typed_ok, directed_rows[r].exp_val);
        drain();

        // shortest slice, unity pitch
        cfg_write(REG_SLICE_LENGTH, 16'd32);
        random_phase(PHASE_ITEMS);
        drain();

        // slowest pitch, reverse
        cfg_write(REG_PITCH_STEP, 16'd205);
        cfg_write(REG_REVERSE_PLAY, 16'd1);
        random_phase(PHASE_ITEMS);
        drain();

        // out-of-range values saturate; spare index must not touch anything
        cfg_write(REG_SLICE_LENGTH, 16'd0);
        cfg_write(REG_PITCH_STEP, 16'hFFFF);
        cfg_write(REG_REVERSE_PLAY, 16'hFFFE);
        cfg_write(REG_SPARE, 16'h0020);
        random_phase(PHASE_ITEMS);
        drain();

        // fastest pitch, reverse, with a long output stall to back up the input
        cfg_write(REG_SLICE_LENGTH, 16'd100);
        cfg_write(REG_PITCH_STEP, 16'd16384);
        cfg_write(REG_REVERSE_PLAY, 16'd1);
        hold_asks = hold_asks + 1;
        random_phase(PHASE_ITEMS);
        drain();

        // longest slice (clamped from the all-ones value)
        cfg_write(REG_SLICE_LENGTH, 16'hFFFF);
        cfg_write(REG_PITCH_STEP, 16'd3000);
        cfg_write(REG_REVERSE_PLAY, 16'd0);
        random_phase(PHASE_ITEMS);
        drain();

        // shrink the slice while still armed: offset wraps into the new length
        cfg_write(REG_SLICE_LENGTH, 16'd48);
        cfg_write(REG_PITCH_STEP, 16'd5000);
        cfg_write(REG_REVERSE_PLAY, 16'd1);
        random_phase(PHASE_ITEMS);
        drain();

        // closing phase runs back to back
        cfg_write(REG_SLICE_LENGTH, 16'd64);
        cfg_write(REG_PITCH_STEP, 16'd4096);
        cfg_write(REG_REVERSE_PLAY, 16'd0);
        quiet = 1'b1;
        random_phase(PHASE_ITEMS);
        drain();

        if (fail_count == 0)
            $display("PASS audio_stutter_looper");
        else
            $display("FAIL audio_stutter_looper");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: checks each output transfer, random stall bursts,
    // one long hold-off on request
    // ------------------------------------------------------------------
    int stall_left;
    int hold_left;
    int hold_seen;
    logic signed [SAMPLE_W-1:0] want;

    initial
    begin
        out_ch.ready = 1'b0;
        stall_left   = 0;
        hold_left    = 0;
        hold_seen    = 0;
    end

    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
        begin
            if (pending_out.size() == 0)
            begin
                $error("out_sample: no result expected, actual %0d", out_ch.out_sample);
                fail_count++;
            end
            else
            begin
                want = pending_out.pop_front();
                if (out_ch.out_sample !== want)
                begin
                    $error("out_sample: expected %0d, actual %0d", want, out_ch.out_sample);
                    fail_count++;
                end
            end
        end

        if (hold_seen != hold_asks)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end

        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else if (quiet || !rst_n)
            out_ch.ready <= rst_n;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // Watchdog: cycles without any transfer on either channel
    int idle_cycles;
    initial idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL audio_stutter_looper");
            $finish;
        end
    end

endmodule
`default_nettype wire
